[rtl/hta_pkg.sv]
// Package for the homogeneous transform accumulator.
// Operation codes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package hta_pkg;
	typedef enum logic [2:0] {
		OP_IDENT = 3'd0,
		OP_WRITE = 3'd1,
		OP_READ  = 3'd2,
		OP_TRANS = 3'd3,
		OP_ROTX  = 3'd4,
		OP_ROTY  = 3'd5,
		OP_ROTZ  = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam int ATAN_LEN = 24;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] v;
		unique case (i)
			5'd0: v = 36'sd843314856;
			5'd1: v = 36'sd497837829;
			5'd2: v = 36'sd263043836;
			5'd3: v = 36'sd133525158;
			5'd4: v = 36'sd67021686;
			5'd5: v = 36'sd33543515;
			5'd6: v = 36'sd16775850;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194282;
			5'd9: v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			default: v = 36'sd0;
		endcase
		return v;
	endfunction

	// handshake between sequencer and CORDIC
	typedef struct packed {
		logic start;
		logic signed [19:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] sin_v;
		logic signed [31:0] cos_v;
	} cordic_rsp_t;
endpackage
`default_nettype wire

[rtl/hta_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on hta_pkg.
`default_nettype none
module hta_cordic import hta_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cordic_req_t req,
	output cordic_rsp_t      rsp
);
	localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	logic               busy_q;
	logic [4:0]         step_q;
	logic               flip_q;
	logic signed [35:0] x_q, y_q, z_q;
	logic               done_q;
	logic signed [31:0] sin_q, cos_q;

	logic signed [35:0] z0, z1, xs, ys, xf, yf;
	logic               flip0;

	always_comb begin
		z0 = 36'(req.angle) <<< 14;
		if (z0 > PI_Q30) z0 = z0 - TWO_PI_Q30;
		else if (z0 < -PI_Q30) z0 = z0 + TWO_PI_Q30;
		flip0 = 1'b0;
		z1 = z0;
		if (z0 > HALF_PI_Q30) begin
			z1 = z0 - PI_Q30;
			flip0 = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			z1 = z0 + PI_Q30;
			flip0 = 1'b1;
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == 5'(NSTEP));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
				flip_q <= flip0;
				x_q <= 36'(GAIN_Q30);
				y_q <= '0;
				z_q <= z1;
			end else if (busy_q) begin
				if (step_q == 5'(NSTEP)) begin
					busy_q <= 1'b0;
					cos_q <= 32'((xf + 36'sd8192) >>> 14);
					sin_q <= 32'((yf + 36'sd8192) >>> 14);
				end else begin
					if (!z_q[35]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_q30(step_q);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_q30(step_q);
					end
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.sin_v = sin_q;
	assign rsp.cos_v = cos_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("cordic done without run");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 5'(NSTEP)) else $error("cordic step overrun");
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("cordic done while busy");
endmodule
`default_nettype wire

[rtl/homogeneous_transform_accumulator.sv]
// Homogeneous transform accumulator: 4x4 Q16.16 matrix under a command port.
//
// Usage: drive operation and the operand fields with start high while busy is
// low; that edge is the input transfer. busy rises next cycle and holds until
// the single result is shown: done pulses for one cycle with read_value and
// the translation column pos_x/pos_y/pos_z. The receiver cannot stall; the
// result must be taken in that cycle.
// From transfer to result: identity, write, read and unused codes go
// straight to the result state. Translate runs all 64 products of the
// 4x4 right multiply on the one shared 32x32 multiplier, then a copy-back
// state and the result state. Rotations first run the CORDIC (with launch
// and capture), then the same 64-product pass. The next transfer can be
// taken at the result edge; none is taken before the last result is shown.
// Reset: the matrix returns to identity at once (registered elements with
// async reset), busy and done clear.
// Depends on hta_pkg and hta_cordic.
`default_nettype none
module homogeneous_transform_accumulator import hta_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	input  wire logic [2:0]         operation,
	input  wire logic [1:0]         row_index,
	input  wire logic [1:0]         col_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic signed [31:0] shift_x,
	input  wire logic signed [31:0] shift_y,
	input  wire logic signed [31:0] shift_z,
	input  wire logic signed [19:0] angle,
	output logic signed [31:0]      read_value,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z
);
	typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_MAC, S_STORE, S_DONE} state_t;

	state_t             state_q;
	logic signed [31:0] m_q [16];
	logic signed [31:0] res_q [16];
	op_t                op_q;
	logic signed [31:0] bs_q [3];
	logic signed [19:0] ang_q;
	logic signed [31:0] sin_q, cos_q;
	logic [1:0]         r_q, c_q, k_q;
	logic signed [49:0] acc_q;
	cordic_req_t        creq;
	cordic_rsp_t        crsp;

	hta_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	assign creq.start = (state_q == S_CORDIC) && !crsp.done;
	assign creq.angle = ang_q;

	// element of the right-hand matrix at (k, c)
	function automatic logic signed [31:0] b_elem(input op_t op, input logic [1:0] k,
			input logic [1:0] c, input logic signed [31:0] s, input logic signed [31:0] co,
			input logic signed [31:0] tx, input logic signed [31:0] ty,
			input logic signed [31:0] tz);
		logic signed [31:0] v;
		v = (k == c) ? ONE_Q16 : 32'sd0;
		unique case (op)
			OP_TRANS: if (c == 2'd3 && k != 2'd3)
				v = (k == 2'd0) ? tx : (k == 2'd1) ? ty : tz;
			OP_ROTX: begin
				if (k == 2'd1 && c == 2'd1) v = co;
				if (k == 2'd1 && c == 2'd2) v = -s;
				if (k == 2'd2 && c == 2'd1) v = s;
				if (k == 2'd2 && c == 2'd2) v = co;
			end
			OP_ROTY: begin
				if (k == 2'd0 && c == 2'd0) v = co;
				if (k == 2'd0 && c == 2'd2) v = s;
				if (k == 2'd2 && c == 2'd0) v = -s;
				if (k == 2'd2 && c == 2'd2) v = co;
			end
			OP_ROTZ: begin
				if (k == 2'd0 && c == 2'd0) v = co;
				if (k == 2'd0 && c == 2'd1) v = -s;
				if (k == 2'd1 && c == 2'd0) v = s;
				if (k == 2'd1 && c == 2'd1) v = co;
			end
			default: ;
		endcase
		return v;
	endfunction

	logic signed [31:0] a_op, b_op;
	logic signed [63:0] prod;
	logic signed [47:0] prod_r;
	logic signed [49:0] acc_n;
	logic signed [31:0] sat_v;

	always_comb begin
		a_op = m_q[{r_q, k_q}];
		b_op = b_elem(op_q, k_q, c_q, sin_q, cos_q, bs_q[0], bs_q[1], bs_q[2]);
		prod = a_op * b_op;
		prod_r = 48'((prod + 64'sd32768) >>> 16);
		// four rounded products of up to 2^46 each need 50 bits
		acc_n = ((k_q == 2'd0) ? 50'sd0 : acc_q) + 50'(prod_r);
		if (acc_n > 50'sd2147483647) sat_v = 32'sh7fffffff;
		else if (acc_n < -50'sd2147483648) sat_v = 32'sh80000000;
		else sat_v = 32'(acc_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			for (int i = 0; i < 16; i++)
				m_q[i] <= (i % 5 == 0) ? ONE_Q16 : 32'sd0;
		end else begin
			done <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= op_t'(operation);
					bs_q[0] <= shift_x;
					bs_q[1] <= shift_y;
					bs_q[2] <= shift_z;
					ang_q <= angle;
					r_q <= '0; c_q <= '0; k_q <= '0;
					read_value <= (op_t'(operation) == OP_READ) ?
						m_q[{row_index, col_index}] : '0;
					unique case (op_t'(operation))
						OP_IDENT: begin
							for (int i = 0; i < 16; i++)
								m_q[i] <= (i % 5 == 0) ? ONE_Q16 : 32'sd0;
							state_q <= S_DONE;
						end
						OP_WRITE: begin
							m_q[{row_index, col_index}] <= element_value;
							state_q <= S_DONE;
						end
						OP_TRANS: state_q <= S_MAC;
						OP_ROTX, OP_ROTY, OP_ROTZ: state_q <= S_CORDIC;
						default: state_q <= S_DONE;
					endcase
				end
				S_CORDIC: if (crsp.done) begin
					sin_q <= crsp.sin_v;
					cos_q <= crsp.cos_v;
					state_q <= S_MAC;
				end
				S_MAC: begin
					// one product per cycle over all 64 terms
					acc_q <= acc_n;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						res_q[{r_q, c_q}] <= sat_v;
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3) begin
							r_q <= r_q + 2'd1;
							if (r_q == 2'd3) state_q <= S_STORE;
						end
					end
				end
				S_STORE: begin
					for (int i = 0; i < 16; i++) m_q[i] <= res_q[i];
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign pos_x = m_q[3];
	assign pos_y = m_q[7];
	assign pos_z = m_q[11];

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done outside idle");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer not taken");
endmodule
`default_nettype wire
